>>> design/mipmap_box_downsample_defines.svh
// Assertion macros used by the top-level file to check the block.
`ifndef MIPMAP_BOX_DOWNSAMPLE_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_DEFINES_SVH

`ifndef SYNTH
`define MBD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MBD_ASSERT_SAME(lbl, ante, cons)
`define MBD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/mbd_pkg.sv
package mbd_pkg;

  localparam int MAX_SIDE    = 64;
  localparam int PIX_W       = 8;
  localparam int COORD_W     = 6;
  localparam int DIM_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int LEVELS      = 4;

  localparam int SUM2_W = PIX_W + 2;
  localparam int SUM4_W = PIX_W + 4;
  localparam int SUM8_W = PIX_W + 6;

  localparam int COLS2 = MAX_SIDE / 2;
  localparam int COLS4 = MAX_SIDE / 4;
  localparam int COLS8 = MAX_SIDE / 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_SIZE = 1'b1;

  typedef struct packed {
    logic               bad;
    logic [LEVELS-1:0]  mask;
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   mean1;
    logic [PIX_W-1:0]   mean2;
    logic [PIX_W-1:0]   mean3;
    logic               frame_end;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic size_ok(input logic [DIM_W-1:0] side);
    return (side != '0) && (side[3:0] == 4'd0) && (side <= DIM_W'(MAX_SIDE));
  endfunction

endpackage

>>> design/mipmap_box_downsample.sv
// Box-filter mip chain generator for an 8-bit image streamed in raster order.
// The input channel (in_valid, in_stall, pixel) takes one pixel word per cycle
// while the internal job queue has room. Each pixel gives its level 0 word and,
// when it closes a 2x2, 4x4 or 8x8 block, the truncated block mean for level 1,
// 2 or 3, in level order, with run_last on the final word of the pixel.
// The output channel (out_valid, out_stall and the result fields) carries one
// word per cycle while out_stall is low; all words leave through that single
// output port, which bounds the throughput of a long frame.
// A pixel goes through the job queue, then the output register, to the outputs.
// When out_stall is high the output word holds, the queue fills, and in_stall
// rises once all queue entries are taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the image width or height, any write restarts the frame, cfg_ready stays high.
// Sides of 0, over 64 or not multiples of 16 give one bad_size word per pixel.
// Reset restores a 16 by 16 frame and clears all sums and the queue at once.
module mipmap_box_downsample #(
  parameter int QUEUE_DEPTH = mbd_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mbd_pkg::PIX_W-1:0]     pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [1:0]                    level,
  output logic [mbd_pkg::COORD_W-1:0]   out_x,
  output logic [mbd_pkg::COORD_W-1:0]   out_y,
  output logic [mbd_pkg::PIX_W-1:0]     value,
  output logic                          frame_end,
  output logic                          run_last
);
  import mbd_pkg::*;

  job_t          job;
  job_t          head;
  queue_status_t q_status;
  logic          accept;
  logic          pop;
  logic          cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = q_status.full;
  assign accept    = in_valid && !in_stall;

  mbd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .pixel     (pixel),
    .job       (job)
  );

  mbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  mbd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .level     (level),
    .out_x     (out_x),
    .out_y     (out_y),
    .value     (value),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

`include "mipmap_box_downsample_defines.svh"

  `MBD_ASSERT_NEXT(a_push_fills, accept, !q_status.empty)
  `MBD_ASSERT_NEXT(a_level_order, out_valid && !out_stall && !run_last, out_valid && (level > $past(level)))
  `MBD_ASSERT_SAME(a_bad_word_alone, out_valid && (status == STATUS_BAD_SIZE), run_last && (level == 2'd0) && !frame_end)

endmodule

>>> design/mbd_front.sv
module mbd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbd_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          accept,
  input  logic [mbd_pkg::PIX_W-1:0]     pixel,
  output mbd_pkg::job_t                 job
);
  import mbd_pkg::*;

  localparam int I2_W = $clog2(COLS2);
  localparam int I4_W = $clog2(COLS4);
  localparam int I8_W = $clog2(COLS8);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [COORD_W-1:0] column_count;
  logic [COORD_W-1:0] row_count;
  logic [SUM2_W-1:0]  sum_two   [COLS2];
  logic [SUM4_W-1:0]  sum_four  [COLS4];
  logic [SUM8_W-1:0]  sum_eight [COLS8];

  logic [I2_W-1:0]    i2;
  logic [I4_W-1:0]    i4;
  logic [I8_W-1:0]    i8;
  logic [SUM2_W-1:0]  s2_next;
  logic [SUM4_W-1:0]  s4_next;
  logic [SUM8_W-1:0]  s8_next;
  logic               e1, e2, e3;
  logic               ok;
  logic [DIM_W-1:0]   x_inc;
  logic [DIM_W-1:0]   y_inc;
  logic               row_done;
  logic               frame_done;

  assign i2 = column_count[COORD_W-1:1];
  assign i4 = column_count[COORD_W-1:2];
  assign i8 = column_count[COORD_W-1:3];

  assign x_inc = {1'b0, column_count} + DIM_W'(1);
  assign y_inc = {1'b0, row_count} + DIM_W'(1);

  assign ok = size_ok(image_width) && size_ok(image_height) &&
              ({1'b0, column_count} < image_width) && ({1'b0, row_count} < image_height);

  assign s2_next = sum_two[i2] + SUM2_W'(pixel);
  assign s4_next = sum_four[i4] + SUM4_W'(pixel);
  assign s8_next = sum_eight[i8] + SUM8_W'(pixel);

  assign e1 = column_count[0] & row_count[0];
  assign e2 = (column_count[1:0] == 2'b11) && (row_count[1:0] == 2'b11);
  assign e3 = (column_count[2:0] == 3'b111) && (row_count[2:0] == 3'b111);

  assign row_done   = (x_inc >= image_width);
  assign frame_done = (y_inc >= image_height);

  always_comb begin
    job = '0;
    if (ok) begin
      job.bad       = STATUS_OK;
      job.mask      = {e3, e2, e1, 1'b1};
      job.pixel     = pixel;
      job.x         = column_count;
      job.y         = row_count;
      job.mean1     = s2_next[SUM2_W-1:2];
      job.mean2     = s4_next[SUM4_W-1:4];
      job.mean3     = s8_next[SUM8_W-1:6];
      job.frame_end = (x_inc == image_width) && (y_inc == image_height);
    end else begin
      job.bad  = STATUS_BAD_SIZE;
      job.mask = LEVELS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(16);
      image_height <= DIM_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      column_count <= '0;
      row_count    <= '0;
      for (int k = 0; k < COLS2; k++) sum_two[k]   <= '0;
      for (int k = 0; k < COLS4; k++) sum_four[k]  <= '0;
      for (int k = 0; k < COLS8; k++) sum_eight[k] <= '0;
    end else if (accept && ok) begin
      sum_two[i2]   <= e1 ? '0 : s2_next;
      sum_four[i4]  <= e2 ? '0 : s4_next;
      sum_eight[i8] <= e3 ? '0 : s8_next;
      if (row_done) begin
        column_count <= '0;
        row_count    <= frame_done ? '0 : y_inc[COORD_W-1:0];
      end else begin
        column_count <= x_inc[COORD_W-1:0];
      end
    end
  end

endmodule

>>> design/mbd_queue.sv
module mbd_queue #(
  parameter int DEPTH = mbd_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  mbd_pkg::job_t         push_data,
  input  logic                  pop,
  output mbd_pkg::job_t         head,
  output mbd_pkg::queue_status_t q_status
);
  import mbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head           = mem[rd_ptr];
  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

>>> design/mbd_back.sv
module mbd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  mbd_pkg::job_t               head,
  input  mbd_pkg::queue_status_t      q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        status,
  output logic [1:0]                  level,
  output logic [mbd_pkg::COORD_W-1:0] out_x,
  output logic [mbd_pkg::COORD_W-1:0] out_y,
  output logic [mbd_pkg::PIX_W-1:0]   value,
  output logic                        frame_end,
  output logic                        run_last
);
  import mbd_pkg::*;

  logic [LEVELS-1:0]  done;
  logic [LEVELS-1:0]  remaining;
  logic [LEVELS-1:0]  sel;
  logic [LEVELS-1:0]  left_after;
  logic [1:0]         lvl;
  logic               take;
  logic [PIX_W-1:0]   val_sel;

  assign remaining  = head.mask & ~done;
  assign sel        = remaining & (~remaining + LEVELS'(1));
  assign left_after = remaining & ~sel;
  assign take       = !q_status.empty && (!out_valid || !out_stall);
  assign pop        = take && (left_after == '0);

  always_comb begin
    lvl = 2'd0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (remaining[i]) lvl = 2'(i);
    end
  end

  always_comb begin
    case (lvl)
      2'd0:    val_sel = head.pixel;
      2'd1:    val_sel = head.mean1;
      2'd2:    val_sel = head.mean2;
      2'd3:    val_sel = head.mean3;
      default: val_sel = head.pixel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        done      <= pop ? '0 : (done | sel);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status    <= head.bad;
      level     <= lvl;
      out_x     <= head.x >> lvl;
      out_y     <= head.y >> lvl;
      value     <= val_sel;
      frame_end <= head.frame_end;
      run_last  <= (left_after == '0);
    end
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  localparam logic [1:0] LVL_PIXEL = 2'd0;
  localparam logic [1:0] LVL_2X2   = 2'd1;
  localparam logic [1:0] LVL_4X4   = 2'd2;
  localparam logic [1:0] LVL_8X8   = 2'd3;

  localparam int MAX_WAIT     = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int STUCK_LIMIT  = 2000;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic               status;
    logic [1:0]         level;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   value;
    logic               frame_end;
    logic               run_last;
  } mip_word_t;

  bit                    clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DIM_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel;
  logic                  out_valid;
  logic                  out_stall;
  logic                  status;
  logic [1:0]            level;
  logic [COORD_W-1:0]    out_x;
  logic [COORD_W-1:0]    out_y;
  logic [PIX_W-1:0]      value;
  logic                  frame_end;
  logic                  run_last;

  mipmap_box_downsample u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .pixel     (pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .level     (level),
    .out_x     (out_x),
    .out_y     (out_y),
    .value     (value),
    .frame_end (frame_end),
    .run_last  (run_last)
  );

  logic [DIM_W-1:0]  img_w;
  logic [DIM_W-1:0]  img_h;
  int                col_pos;
  int                row_pos;
  logic [SUM2_W-1:0] acc2 [COLS2];
  logic [SUM4_W-1:0] acc4 [COLS4];
  logic [SUM8_W-1:0] acc8 [COLS8];

  mip_word_t expected_words [$];
  int        error_count  = 0;
  int        stuck_cycles = 0;
  int        sink_hold    = 0;
  bit        src_quiet    = 1'b0;
  bit        sink_quiet   = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit side_legal(input logic [DIM_W-1:0] s);
    return (s != '0) && (s[3:0] == 4'd0) && (s <= DIM_W'(MAX_SIDE));
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    foreach (acc2[i]) acc2[i] = '0;
    foreach (acc4[i]) acc4[i] = '0;
    foreach (acc8[i]) acc8[i] = '0;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [DIM_W-1:0] data);
    if (idx == REG_IMAGE_WIDTH) begin
      img_w = data;
    end else if (idx == REG_IMAGE_HEIGHT) begin
      img_h = data;
    end
    restart_frame();
  endfunction

  function automatic mip_word_t make_word(input logic [1:0] lv, input int x, input int y,
                                          input logic [PIX_W-1:0] v);
    mip_word_t w;
    w = '0;
    w.status = STATUS_OK;
    w.level  = lv;
    w.x      = COORD_W'(x);
    w.y      = COORD_W'(y);
    w.value  = v;
    return w;
  endfunction

  // For a legal size, accumulates the pixel into its column sums and queues the
  // level 0 word plus the mean of each block it closes, else one bad_size word.
  function automatic void predict_pixel(input logic [PIX_W-1:0] p);
    mip_word_t batch [LEVELS];
    int        n;
    int        x2;
    int        x4;
    int        x8;
    logic      last;
    n = 0;
    if (!side_legal(img_w) || !side_legal(img_h) || col_pos >= img_w || row_pos >= img_h) begin
      batch[0] = '0;
      batch[0].status   = STATUS_BAD_SIZE;
      batch[0].run_last = 1'b1;
      expected_words.push_back(batch[0]);
      return;
    end
    x2 = col_pos >> 1;
    x4 = col_pos >> 2;
    x8 = col_pos >> 3;
    batch[n] = make_word(LVL_PIXEL, col_pos, row_pos, p);
    n++;
    acc2[x2] = acc2[x2] + p;
    acc4[x4] = acc4[x4] + p;
    acc8[x8] = acc8[x8] + p;
    if ((col_pos & 1) == 1 && (row_pos & 1) == 1) begin
      batch[n] = make_word(LVL_2X2, x2, row_pos >> 1, acc2[x2][SUM2_W-1:2]);
      n++;
      acc2[x2] = '0;
    end
    if ((col_pos & 3) == 3 && (row_pos & 3) == 3) begin
      batch[n] = make_word(LVL_4X4, x4, row_pos >> 2, acc4[x4][SUM4_W-1:4]);
      n++;
      acc4[x4] = '0;
    end
    if ((col_pos & 7) == 7 && (row_pos & 7) == 7) begin
      batch[n] = make_word(LVL_8X8, x8, row_pos >> 3, acc8[x8][SUM8_W-1:6]);
      n++;
      acc8[x8] = '0;
    end
    last = (col_pos + 1 == img_w) && (row_pos + 1 == img_h);
    batch[n-1].run_last = 1'b1;
    for (int k = 0; k < n; k++) begin
      batch[k].frame_end = last;
      expected_words.push_back(batch[k]);
    end
    if (col_pos + 1 >= img_w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= img_h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  function automatic int draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int draw_side();
    case ($urandom_range(0, 5))
      3: return 32;
      4: return 48;
      5: return 64;
      default: return 16;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] draw_bad_side();
    logic [DIM_W-1:0] s;
    do s = DIM_W'($urandom_range(0, 127)); while (side_legal(s));
    return s;
  endfunction

  task automatic report(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int gap;
    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
    if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
    gap = draw_wait(src_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    predict_pixel(p);
    in_valid <= 1'b1;
    pixel    <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic await_drain();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    await_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg_write(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  task automatic test_block_means();
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd1);
    send_pixel(8'd2);
    repeat (12) send_pixel(draw_pixel());
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd3);
    send_pixel(8'd0);
  endtask

  task automatic test_bad_sizes();
    write_reg(REG_IMAGE_WIDTH, 7'd0);
    send_pixel(8'hA5);
    write_reg(REG_IMAGE_WIDTH, 7'd127);
    send_pixel(8'h5A);
    write_reg(REG_IMAGE_WIDTH, 7'd80);
    send_pixel(8'hFF);
    set_size(7'd16, 7'd24);
    send_pixel(8'h00);
  endtask

  task automatic test_unmapped_index();
    set_size(7'd32, 7'd16);
    send_pixel(8'h11);
    send_pixel(8'h22);
    write_reg(REG_UNUSED_2, 7'd127);
    send_pixel(8'h33);
    write_reg(REG_UNUSED_3, 7'd0);
    send_pixel(8'h44);
  endtask

  task automatic test_frame_wrap();
    set_size(7'd16, 7'd16);
    repeat (16 * 16 + 4) send_pixel(draw_pixel());
  endtask

  task automatic test_random_phases();
    int sent;
    int w;
    int h;
    int n;
    set_size(7'd64, 7'd64);
    repeat (64 + 2) send_pixel(draw_pixel());
    sent = 0;
    while (sent < 20) begin
      case ($urandom_range(0, 7))
        0: begin
          write_reg($urandom_range(0, 1) ? REG_IMAGE_HEIGHT : REG_IMAGE_WIDTH, draw_bad_side());
          n = $urandom_range(2, 6);
        end
        1: begin
          write_reg($urandom_range(0, 1) ? REG_UNUSED_3 : REG_UNUSED_2, DIM_W'($urandom));
          n = $urandom_range(8, 24);
        end
        default: begin
          w = draw_side();
          h = draw_side();
          set_size(DIM_W'(w), DIM_W'(h));
          n = w + 2 + $urandom_range(0, 8);
        end
      endcase
      repeat (n) send_pixel(draw_pixel());
      sent += n;
    end
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      out_stall <= 1'b1;
      sink_hold = sink_hold - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : result_check
    mip_word_t want;
    if (!rst && out_valid && !out_stall) begin
      sink_hold = draw_wait(sink_quiet);
      if (expected_words.size() == 0) begin
        report($sformatf("word with nothing expected (level %0d x %0d y %0d value %0d)",
                         level, out_x, out_y, value));
      end else begin
        want = expected_words.pop_front();
        check_field("status", status, want.status);
        check_field("level", level, want.level);
        check_field("out_x", out_x, want.x);
        check_field("out_y", out_y, want.y);
        check_field("value", value, want.value);
        check_field("frame_end", frame_end, want.frame_end);
        check_field("run_last", run_last, want.run_last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles = stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("watchdog: no handshake in %0d cycles, %0d words outstanding",
               STUCK_LIMIT, expected_words.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    pixel     = '0;
    out_stall = 1'b0;
    img_w     = DIM_W'(16);
    img_h     = DIM_W'(16);
    restart_frame();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_block_means();
    test_bad_sizes();
    test_unmapped_index();
    test_frame_wrap();
    test_random_phases();
    await_drain();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> mipmap_box_downsample.f
+incdir+design
design/mbd_pkg.sv
design/mbd_front.sv
design/mbd_queue.sv
design/mbd_back.sv
design/mipmap_box_downsample.sv
tb/tb.sv
